// ===== src/sau_hp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the encoding table of the audio header parser.
// No dependencies; used by sun_au_header_parser_top, sau_hp_div and the bench.
package sau_hp_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned CountW      = $clog2(HeaderBytes + 1);
  localparam int unsigned IdxW        = $clog2(HeaderBytes);
  localparam int unsigned BitsW       = 7;
  localparam int unsigned AddrW       = 3;

  localparam logic [DataW-1:0] Magic       = 32'h2e736e64;
  localparam logic [DataW-1:0] SizeAllOnes = 32'hffffffff;
  localparam logic [DataW-1:0] DefRate     = 32'd8000;
  localparam logic [DataW-1:0] DefKbps     = 32'd8;
  localparam logic [DataW-1:0] KbpsDiv     = 32'd1000;
  localparam logic [DataW-1:0] MinOffset   = 32'd24;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdEof  = 1'b1;

  localparam logic RegFileSize = 1'b0;

  localparam logic [DataW-1:0] EncMulaw8  = 32'd1;
  localparam logic [DataW-1:0] EncLinear8 = 32'd2;
  localparam logic [DataW-1:0] EncLin16   = 32'd3;
  localparam logic [DataW-1:0] EncLin24   = 32'd4;
  localparam logic [DataW-1:0] EncLin32   = 32'd5;
  localparam logic [DataW-1:0] EncFloat   = 32'd6;
  localparam logic [DataW-1:0] EncDouble  = 32'd7;
  localparam logic [DataW-1:0] EncAlaw8   = 32'd27;

  function automatic logic [BitsW-1:0] bits_of(input logic [DataW-1:0] enc);
    logic [BitsW-1:0] bits;
    case (enc)
      EncMulaw8:  bits = 7'd8;
      EncLinear8: bits = 7'd8;
      EncLin16:   bits = 7'd16;
      EncLin24:   bits = 7'd24;
      EncLin32:   bits = 7'd32;
      EncFloat:   bits = 7'd32;
      EncDouble:  bits = 7'd64;
      EncAlaw8:   bits = 7'd8;
      default:    bits = 7'd0;
    endcase
    return bits;
  endfunction

endpackage

// ===== src/sau_hp_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sau_hp_pkg for the data width.
module sau_hp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sau_hp_pkg::DataW-1:0] dividend_i,
  input  logic [sau_hp_pkg::DataW-1:0] divisor_i,
  output logic                         done_o,
  output logic [sau_hp_pkg::DataW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(sau_hp_pkg::DataW);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [StepW-1:0]             step_q, step_d;
  logic [sau_hp_pkg::DataW:0]   rem_q, rem_d;
  logic [sau_hp_pkg::DataW-1:0] quo_q, quo_d;
  logic [sau_hp_pkg::DataW-1:0] dvs_q, dvs_d;
  logic [sau_hp_pkg::DataW:0]   rem_sh;
  logic [sau_hp_pkg::DataW:0]   rem_sub;

  assign rem_sh  = {rem_q[sau_hp_pkg::DataW-1:0], quo_q[sau_hp_pkg::DataW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!rem_sub[sau_hp_pkg::DataW]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[sau_hp_pkg::DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[sau_hp_pkg::DataW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(sau_hp_pkg::DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/sun_au_header_parser_top.sv =====
`timescale 1ns / 1ps
// Audio file header parser: collects the first 24 file bytes and decodes them.
// Depends on sau_hp_pkg and sau_hp_div.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command and one byte per
//   item. A byte item with command 0 is taken while in_ready_o is high. The
//   24th byte, or an end-of-file item before 24 bytes, starts the computation
//   and raises one result item on the output channel (out_valid_o/out_ready_i).
//   A parsed header goes through a parse state, two passes through one shared
//   32x32 multiplier, then the shared bit-serial divider for the bitrate and,
//   if that is nonzero, the length. A default result takes one divider pass
//   (length); an offset error skips the multiplier and the divider. in_ready_o
//   stays low during this work. The result sits in an output register; the
//   parser returns to taking bytes while it waits. If the receiver stalls and
//   a second result is ready, the sequencer holds it until the output register
//   frees. file_size is written over the APB port at address 0; the user must
//   write it only while the block idles, which the block does not enforce.
//   Reset clears the byte count, the sequencer, the output valid and file_size;
//   the header store is not cleared.
module sun_au_header_parser_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sau_hp_pkg::AddrW-1:0]      paddr,
  input  logic [sau_hp_pkg::DataW-1:0]      pwdata,
  output logic [sau_hp_pkg::DataW-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [7:0]                        header_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              has_header_o,
  output logic                              offset_error_o,
  output logic [sau_hp_pkg::DataW-1:0]      sample_rate_o,
  output logic [sau_hp_pkg::DataW-1:0]      bitrate_kbps_o,
  output logic [sau_hp_pkg::DataW-1:0]      data_bytes_o,
  output logic [sau_hp_pkg::DataW-1:0]      length_ms_o
);

  typedef enum logic [3:0] {
    StIdle,
    StParse,
    StMulBits,
    StMulRate,
    StKbpsGo,
    StKbpsWait,
    StLenGo,
    StLenWait,
    StFinish
  } state_e;

  localparam int unsigned W = sau_hp_pkg::DataW;

  state_e                          state_q;
  logic [sau_hp_pkg::CountW-1:0]   cnt_q;
  logic [W-1:0]                    file_size_q;
  logic [7:0]                      store_q [sau_hp_pkg::HeaderBytes];
  logic                            hdr_q, err_q;
  logic [W-1:0]                    rate_q, kbps_q, bytes_q, len_q, prod_q;
  logic                            out_valid_q, out_hdr_q, out_err_q;
  logic [W-1:0]                    out_rate_q, out_kbps_q, out_bytes_q, out_len_q;

  logic                            in_acc, cfg_wr, out_free, store_wr;
  logic [W-1:0]                    w_magic, w_off, w_size, w_enc, w_rate, w_chans;
  logic [W-1:0]                    mul_a, mul_b;
  logic [W-1:0]                    mul_lo;
  logic                            div_start, div_done;
  logic [W-1:0]                    div_dvd, div_dvs, div_quo;

  assign w_magic = {store_q[0], store_q[1], store_q[2], store_q[3]};
  assign w_off   = {store_q[4], store_q[5], store_q[6], store_q[7]};
  assign w_size  = {store_q[8], store_q[9], store_q[10], store_q[11]};
  assign w_enc   = {store_q[12], store_q[13], store_q[14], store_q[15]};
  assign w_rate  = {store_q[16], store_q[17], store_q[18], store_q[19]};
  assign w_chans = {store_q[20], store_q[21], store_q[22], store_q[23]};

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == sau_hp_pkg::RegFileSize);
  assign prdata     = (paddr[2] == sau_hp_pkg::RegFileSize) ? file_size_q : '0;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign store_wr   = in_acc && (command_i == sau_hp_pkg::CmdByte)
                      && (cnt_q < sau_hp_pkg::CountW'(sau_hp_pkg::HeaderBytes));

  assign mul_a  = (state_q == StMulBits) ? W'(sau_hp_pkg::bits_of(w_enc)) : prod_q;
  assign mul_b  = (state_q == StMulBits) ? w_chans : rate_q;
  assign mul_lo = mul_a * mul_b;

  assign div_start = (state_q == StKbpsGo) || ((state_q == StLenGo) && (kbps_q != '0));
  assign div_dvd   = (state_q == StKbpsGo) ? prod_q : {bytes_q[W-4:0], 3'b000};
  assign div_dvs   = (state_q == StKbpsGo) ? sau_hp_pkg::KbpsDiv : kbps_q;

  sau_hp_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[cnt_q[sau_hp_pkg::IdxW-1:0]] <= header_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      file_size_q <= '0;
      out_valid_q <= 1'b0;
      hdr_q       <= 1'b0;
      err_q       <= 1'b0;
      rate_q      <= '0;
      kbps_q      <= '0;
      bytes_q     <= '0;
      len_q       <= '0;
      prod_q      <= '0;
      out_hdr_q   <= 1'b0;
      out_err_q   <= 1'b0;
      out_rate_q  <= '0;
      out_kbps_q  <= '0;
      out_bytes_q <= '0;
      out_len_q   <= '0;
    end else begin
      if (cfg_wr) begin
        file_size_q <= pwdata;
      end
      if ((state_q == StFinish) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (command_i == sau_hp_pkg::CmdEof) begin
              if (cnt_q < sau_hp_pkg::CountW'(sau_hp_pkg::HeaderBytes)) begin
                hdr_q   <= 1'b0;
                err_q   <= 1'b0;
                rate_q  <= sau_hp_pkg::DefRate;
                kbps_q  <= sau_hp_pkg::DefKbps;
                bytes_q <= file_size_q;
                state_q <= StLenGo;
              end
              cnt_q <= '0;
            end else if (store_wr) begin
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q == sau_hp_pkg::CountW'(sau_hp_pkg::HeaderBytes - 1)) begin
                state_q <= StParse;
              end
            end
          end
        end
        StParse: begin
          if (w_magic != sau_hp_pkg::Magic) begin
            hdr_q   <= 1'b0;
            err_q   <= 1'b0;
            rate_q  <= sau_hp_pkg::DefRate;
            kbps_q  <= sau_hp_pkg::DefKbps;
            bytes_q <= file_size_q;
            state_q <= StLenGo;
          end else if (w_off[W-1] || (w_off < sau_hp_pkg::MinOffset)) begin
            hdr_q   <= 1'b0;
            err_q   <= 1'b1;
            rate_q  <= '0;
            kbps_q  <= '0;
            bytes_q <= '0;
            len_q   <= '0;
            state_q <= StFinish;
          end else begin
            hdr_q   <= 1'b1;
            err_q   <= 1'b0;
            rate_q  <= w_rate;
            bytes_q <= (w_size == sau_hp_pkg::SizeAllOnes) ? file_size_q - w_off : w_size;
            state_q <= StMulBits;
          end
        end
        StMulBits: begin
          prod_q  <= mul_lo;
          state_q <= StMulRate;
        end
        StMulRate: begin
          prod_q  <= mul_lo;
          state_q <= StKbpsGo;
        end
        StKbpsGo: begin
          state_q <= StKbpsWait;
        end
        StKbpsWait: begin
          if (div_done) begin
            kbps_q  <= div_quo;
            state_q <= StLenGo;
          end
        end
        StLenGo: begin
          if (kbps_q == '0) begin
            len_q   <= '0;
            state_q <= StFinish;
          end else begin
            state_q <= StLenWait;
          end
        end
        StLenWait: begin
          if (div_done) begin
            len_q   <= div_quo;
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_hdr_q   <= hdr_q;
            out_err_q   <= err_q;
            out_rate_q  <= rate_q;
            out_kbps_q  <= kbps_q;
            out_bytes_q <= bytes_q;
            out_len_q   <= len_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign has_header_o   = out_hdr_q;
  assign offset_error_o = out_err_q;
  assign sample_rate_o  = out_rate_q;
  assign bitrate_kbps_o = out_kbps_q;
  assign data_bytes_o   = out_bytes_q;
  assign length_ms_o    = out_len_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sau_hp_pkg::CountW'(sau_hp_pkg::HeaderBytes))
    else $error("byte count past header length");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StKbpsWait) || (state_q == StLenWait))
    else $error("divider finished outside a wait state");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && offset_error_o |-> !has_header_o && (length_ms_o == '0)
      && (bitrate_kbps_o == '0))
    else $error("offset error item carries nonzero fields");

  a_default_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !offset_error_o && !has_header_o
      |-> (sample_rate_o == sau_hp_pkg::DefRate) && (bitrate_kbps_o == sau_hp_pkg::DefKbps))
    else $error("default item carries wrong rate");
`endif

endmodule

// ===== bench/au_header_checker.sv =====
`timescale 1ns / 1ps
// Checker for the audio header parser: watches the register port and both item
// channels, decodes its own copy of the header store and compares results.
// Depends on sau_hp_pkg.
module au_header_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [sau_hp_pkg::AddrW-1:0] paddr_i,
  input  logic [sau_hp_pkg::DataW-1:0] pwdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         command_i,
  input  logic [7:0]                   header_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         has_header_i,
  input  logic                         offset_error_i,
  input  logic [sau_hp_pkg::DataW-1:0] sample_rate_i,
  input  logic [sau_hp_pkg::DataW-1:0] bitrate_kbps_i,
  input  logic [sau_hp_pkg::DataW-1:0] data_bytes_i,
  input  logic [sau_hp_pkg::DataW-1:0] length_ms_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);
  import sau_hp_pkg::*;

  localparam logic [AddrW-1:0] FileSizeAddr = {RegFileSize, 2'b00};

  typedef struct packed {
    logic             has_header;
    logic             offset_error;
    logic [DataW-1:0] sample_rate;
    logic [DataW-1:0] bitrate_kbps;
    logic [DataW-1:0] data_bytes;
    logic [DataW-1:0] length_ms;
  } au_info_t;

  logic [7:0]       header_store [HeaderBytes];
  int unsigned      bytes_held;
  logic             info_given;
  logic [DataW-1:0] file_size;
  au_info_t         header_info_q [$];
  au_info_t         want;
  int               mismatches;

  function automatic au_info_t finish_info(input logic hdr, input logic [DataW-1:0] rate,
                                           input logic [DataW-1:0] kbps,
                                           input logic [DataW-1:0] nbytes);
    au_info_t info;
    logic [DataW-1:0] bit_total;
    bit_total = nbytes << 3;
    info.has_header = hdr;
    info.offset_error = 1'b0;
    info.sample_rate = rate;
    info.bitrate_kbps = kbps;
    info.data_bytes = nbytes;
    info.length_ms = (kbps == '0) ? '0 : bit_total / kbps;
    return info;
  endfunction

  function automatic logic [DataW-1:0] store_word(input int pos);
    return {header_store[pos], header_store[pos+1], header_store[pos+2], header_store[pos+3]};
  endfunction

  function automatic logic [DataW-1:0] sample_bits(input logic [DataW-1:0] enc);
    logic [DataW-1:0] nbits;
    nbits = '0;
    if (enc == EncMulaw8 || enc == EncLinear8 || enc == EncAlaw8) nbits = 32'd8;
    else if (enc == EncLin16) nbits = 32'd16;
    else if (enc == EncLin24) nbits = 32'd24;
    else if (enc == EncLin32 || enc == EncFloat) nbits = 32'd32;
    else if (enc == EncDouble) nbits = 32'd64;
    return nbits;
  endfunction

  function automatic au_info_t decode_header();
    au_info_t info;
    logic [DataW-1:0] data_offset;
    logic [DataW-1:0] data_size;
    logic [DataW-1:0] prod;
    info = '0;
    if (store_word(0) != Magic) return finish_info(1'b0, DefRate, DefKbps, file_size);
    data_offset = store_word(4);
    if ($signed(data_offset) < $signed(MinOffset)) begin
      info.offset_error = 1'b1;
      return info;
    end
    data_size = store_word(8);
    if (data_size == SizeAllOnes) data_size = file_size - data_offset;
    prod = sample_bits(store_word(12)) * store_word(20);
    prod = prod * store_word(16);
    return finish_info(1'b1, store_word(16), prod / KbpsDiv, data_size);
  endfunction

  task automatic check_field(input string field, input logic [DataW-1:0] exp_val,
                             input logic [DataW-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_info_q.delete();
      bytes_held = 0;
      info_given = 1'b0;
      file_size = '0;
      mismatches = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (header_info_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual rate %0h kbps %0h bytes %0h",
                   $time, sample_rate_i, bitrate_kbps_i, data_bytes_i);
          mismatches++;
        end else begin
          want = header_info_q.pop_front();
          check_field("has_header", 32'(want.has_header), 32'(has_header_i));
          check_field("offset_error", 32'(want.offset_error), 32'(offset_error_i));
          check_field("sample_rate", want.sample_rate, sample_rate_i);
          check_field("bitrate_kbps", want.bitrate_kbps, bitrate_kbps_i);
          check_field("data_bytes", want.data_bytes, data_bytes_i);
          check_field("length_ms", want.length_ms, length_ms_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == CmdEof) begin
          if (!info_given && bytes_held < HeaderBytes)
            header_info_q.push_back(finish_info(1'b0, DefRate, DefKbps, file_size));
          bytes_held = 0;
          info_given = 1'b0;
        end else if (bytes_held < HeaderBytes) begin
          header_store[bytes_held] = header_byte_i;
          bytes_held++;
          if (bytes_held == HeaderBytes && !info_given) begin
            header_info_q.push_back(decode_header());
            info_given = 1'b1;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == FileSizeAddr)
        file_size = pwdata_i;
      pending_o <= header_info_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== bench/tb_sun_au_header_parser_top.sv =====
`timescale 1ns / 1ps
// Top of the audio header parser bench: clock, reset, register writes, header
// item stimulus and output stalls; the verdict comes from au_header_checker.
// Depends on sau_hp_pkg, sun_au_header_parser_top and au_header_checker.
module tb_sun_au_header_parser_top;
  import sau_hp_pkg::*;

  localparam logic [AddrW-1:0] FileSizeAddr = {RegFileSize, 2'b00};
  localparam int               PhaseItems   = 150;
  localparam int               NumPhases    = 7;
  localparam int               IdleCycles   = 100;
  localparam int               EndCycles    = 200;
  localparam int               CycleLimit   = 500000;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             command_i;
  logic [7:0]       header_byte_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             has_header_o;
  logic             offset_error_o;
  logic [DataW-1:0] sample_rate_o;
  logic [DataW-1:0] bitrate_kbps_o;
  logic [DataW-1:0] data_bytes_o;
  logic [DataW-1:0] length_ms_o;

  int               mismatch_count;
  int               pending;
  int               items_sent;
  int               burst_left;
  logic             gaps_on;
  int               stall_left = 0;
  logic [15:0]      rx_cycle = '0;
  int               cycles;

  sun_au_header_parser_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .header_byte_i  (header_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .has_header_o   (has_header_o),
    .offset_error_o (offset_error_o),
    .sample_rate_o  (sample_rate_o),
    .bitrate_kbps_o (bitrate_kbps_o),
    .data_bytes_o   (data_bytes_o),
    .length_ms_o    (length_ms_o)
  );

  au_header_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .command_i        (command_i),
    .header_byte_i    (header_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .has_header_i     (has_header_o),
    .offset_error_i   (offset_error_o),
    .sample_rate_i    (sample_rate_o),
    .bitrate_kbps_i   (bitrate_kbps_o),
    .data_bytes_i     (data_bytes_o),
    .length_ms_i      (length_ms_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_cycle[10:9])
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= 1'($urandom_range(0, 1));
        2'd2: begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 40);
        end
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic hold_off(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    hold_off(1);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] payload);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    header_byte_i <= payload;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left <= 0) begin
      if (gaps_on) hold_off($urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_bytes(input logic [8*HeaderBytes-1:0] hdr, input int n);
    for (int i = 0; i < n; i++) send_item(CmdByte, hdr[8*HeaderBytes-1-8*i -: 8]);
  endtask

  task automatic write_file_size(input logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FileSizeAddr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_file();
    logic [DataW-1:0]         data_offset;
    logic [DataW-1:0]         data_size;
    logic [DataW-1:0]         enc;
    logic [DataW-1:0]         rate;
    logic [DataW-1:0]         chans;
    logic [8*HeaderBytes-1:0] hdr;
    int                       kind;
    int                       n;
    int                       pos;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) drain();
    case ($urandom_range(0, 3))
      0: data_offset = MinOffset;
      1: data_offset = $urandom_range(24, 1024);
      2: data_offset = 32'h7fffffff;
      default: data_offset = {1'b0, 31'($urandom)} | MinOffset;
    endcase
    case ($urandom_range(0, 4))
      0, 1: data_size = SizeAllOnes;
      2: data_size = '0;
      3: data_size = $urandom;
      default: data_size = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: enc = $urandom_range(0, 8);
      3: enc = EncAlaw8;
      4: enc = $urandom;
      default: enc = $urandom_range(9, 40);
    endcase
    case ($urandom_range(0, 5))
      0: rate = DefRate;
      1: rate = 32'd44100;
      2: rate = 32'd48000;
      3: rate = $urandom;
      4: rate = '0;
      default: rate = 32'hffffffff;
    endcase
    case ($urandom_range(0, 3))
      0: chans = 32'd1;
      1: chans = 32'd2;
      2: chans = $urandom_range(0, 8);
      default: chans = $urandom;
    endcase
    if (kind >= 50 && kind < 60) begin
      case ($urandom_range(0, 2))
        0: data_offset = $urandom_range(0, 23);
        1: data_offset = 32'h80000000 | $urandom;
        default: data_offset = 32'hffffffff;
      endcase
    end
    hdr = {Magic, data_offset, data_size, enc, rate, chans};
    if (kind >= 60 && kind < 70) begin
      pos = $urandom_range(0, 3);
      hdr[8*HeaderBytes-1-8*pos -: 8] = hdr[8*HeaderBytes-1-8*pos -: 8] ^
                                        8'($urandom_range(1, 255));
    end else if (kind >= 70 && kind < 78) begin
      for (int w = 0; w < 6; w++) hdr[32*w +: 32] = $urandom;
    end
    if (kind >= 78 && kind < 90) begin
      n = $urandom_range(0, HeaderBytes - 1);
      send_bytes(hdr, n);
      send_item(CmdEof, 8'($urandom));
      items_sent += n + 1;
    end else if (kind >= 90) begin
      n = $urandom_range(1, 30);
      repeat (n) send_item(($urandom_range(0, 4) == 0) ? CmdEof : CmdByte, 8'($urandom));
      items_sent += n;
    end else begin
      send_bytes(hdr, HeaderBytes);
      items_sent += HeaderBytes;
      n = $urandom_range(0, 3);
      repeat (n) send_item(CmdByte, 8'($urandom));
      items_sent += n;
      if ($urandom_range(0, 9) != 0) begin
        send_item(CmdEof, 8'($urandom));
        items_sent++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    command_i = CmdByte;
    header_byte_i = '0;
    items_sent = 0;
    burst_left = 1;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_file_size(32'hffffffff);
    send_item(CmdEof, 8'h00);
    send_bytes({Magic, MinOffset, SizeAllOnes, EncAlaw8, 32'hffffffff, 32'hffffffff},
               HeaderBytes);
    send_item(CmdByte, 8'hff);
    send_item(CmdEof, 8'hff);
    items_sent = 26;
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      hold_off(IdleCycles);
      case (phase)
        0: write_file_size('0);
        1: write_file_size($urandom);
        2: write_file_size(32'hffffffff);
        3: write_file_size(MinOffset);
        4: write_file_size(32'h80000000);
        5: write_file_size($urandom_range(0, 100000));
        default: write_file_size($urandom);
      endcase
      gaps_on = (phase != 2) && ($urandom_range(0, 3) != 0);
      while (items_sent < 26 + (phase + 1) * PhaseItems) send_file();
    end
    drain();
    hold_off(EndCycles);
    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sau_hp_pkg.sv
src/sau_hp_div.sv
src/sun_au_header_parser_top.sv
bench/au_header_checker.sv
bench/tb_sun_au_header_parser_top.sv
